// ===== src/pid_slew_limited_controller_defines.svh =====
// Assertion macros shared by the PID controller checker
`ifndef PID_SLEW_LIMITED_CONTROLLER_DEFINES_SVH
`define PID_SLEW_LIMITED_CONTROLLER_DEFINES_SVH

// Clocked check, muted while reset is held
`define PSLC_ASSERT(lbl, body, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) body) else $error(msg);

// Clocked check that also holds across reset
`define PSLC_ASSERT_ALWAYS(lbl, body, msg) \
  lbl: assert property (@(posedge clk) body) else $error(msg);

`endif

// ===== src/pslc_pkg.sv =====
// Shared constants and types of the slew-limited PID controller
`default_nettype none
package pslc_pkg;

  localparam int ERROR_BITS   = 16;
  localparam int OUTPUT_LIMIT = 127;
  localparam int MS_PER_S     = 1000;
  localparam int TIME_W       = 32;
  localparam int GAIN_W       = 16;
  localparam int THR_W        = 15;
  localparam int SLEW_W       = 16;
  localparam int DRIVE_W      = 8;
  localparam int ACC_W        = 48;
  localparam int RAW_W        = 32;
  localparam int PROD_W       = 64;
  localparam int DIV_W        = 48;
  localparam int REM_W        = 32;
  localparam int QUOT_W       = 39;
  localparam int RATE_W       = 27;
  localparam int NUM_W        = 27;
  localparam int STEP_W       = 38;
  localparam int RES_W        = 40;
  localparam int CNT_W        = 6;
  localparam int MUL_LAST     = GAIN_W - 1;
  localparam int DIV_LAST     = DIV_W - 1;
  localparam int IN_DATA_W    = ((ERROR_BITS + TIME_W + 7) / 8) * 8;
  localparam int CFG_IDX_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP   = 3'd0,
    CFG_KI   = 3'd1,
    CFG_KD   = 3'd2,
    CFG_THR  = 3'd3,
    CFG_SLEW = 3'd4
  } cfg_idx_t;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_IMUL  = 11'b000_0000_0010,
    ST_IACC  = 11'b000_0000_0100,
    ST_ALOAD = 11'b000_0000_1000,
    ST_ADIV  = 11'b000_0001_0000,
    ST_RDIV  = 11'b000_0010_0000,
    ST_PMUL  = 11'b000_0100_0000,
    ST_RAW   = 11'b000_1000_0000,
    ST_BMUL  = 11'b001_0000_0000,
    ST_BDIV  = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_t;

endpackage
`default_nettype wire

// ===== src/pid_slew_limited_controller.sv =====
// Slew-limited PID controller built on a bit-serial multiplier and divider
// An execute request (tuser low) runs from acceptance to result on one serial
// shift-add multiplier, which retires one gain or multiplier bit per cycle, and
// one restoring divider, which retires one quotient bit per cycle. The integral
// product is skipped when |error| is at or below the threshold, the derivative
// divide when no time has elapsed. A reset request (tuser high) gives no result.
// A finished result waits in the output register while the next request is taken.
`default_nettype none
module pid_slew_limited_controller import pslc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] error_sample, [47:16] now_ms
  input  logic                  in_tuser,   // [0] cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DRIVE_W-1:0]    out_tdata,  // [7:0] drive_value
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [GAIN_W-1:0]     cfg_wdata
);

  // configuration
  logic signed [GAIN_W-1:0] kp_r, ki_r, kd_r;
  logic [THR_W-1:0]         thr_r;
  logic [SLEW_W-1:0]        slew_r;

  // loop memory
  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [1:0]                pass_r, pass_nxt;
  logic [TIME_W-1:0]         last_time_r, last_time_nxt;
  logic signed [ERROR_BITS-1:0] prev_err_r, prev_err_nxt;
  logic signed [ACC_W-1:0]   accum_r, accum_nxt;
  logic signed [RAW_W-1:0]   prev_raw_r, prev_raw_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [DRIVE_W-1:0]        out_data_r, out_data_nxt;

  // per-request working registers
  logic signed [ERROR_BITS-1:0] err_r, err_nxt;
  logic signed [ERROR_BITS:0]   derr_r, derr_nxt;
  logic [TIME_W-1:0]         elapsed_r, elapsed_nxt;
  logic signed [QUOT_W-1:0]  q_r, q_nxt;
  logic signed [RATE_W-1:0]  rate_r, rate_nxt;
  logic signed [RAW_W-1:0]   raw_r, raw_nxt;
  logic signed [RAW_W:0]     diff_r, diff_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic                      dneg_r, dneg_nxt;

  // serial multiplier
  logic signed [PROD_W-1:0]  acc_r, acc_nxt, mcand_r, mcand_nxt;
  logic [GAIN_W-1:0]         mplier_r, mplier_nxt;
  logic                      msgn_r, msgn_nxt;

  // serial divider
  logic [DIV_W-1:0]          dvd_r, dvd_nxt;
  logic [REM_W-1:0]          rem_r, rem_nxt, dvsr_r, dvsr_nxt;

  logic                      accept;
  logic signed [ERROR_BITS-1:0] in_err;
  logic [TIME_W-1:0]         in_now, in_elapsed;
  logic [ERROR_BITS-1:0]     in_err_mag;
  logic                      integrate;
  logic signed [PROD_W-1:0]  mul_term, mul_acc;
  logic [REM_W:0]            rtry, rsub;
  logic                      dge;
  logic [REM_W-1:0]          div_rem;
  logic [DIV_W-1:0]          div_dvd;
  logic                      mul_last, div_last;
  logic signed [ACC_W:0]     acc_sum;
  logic signed [ACC_W-1:0]   acc_sat;
  logic [ACC_W-1:0]          accum_mag;
  logic [ERROR_BITS:0]       derr_mag;
  logic [NUM_W-1:0]          num_mag;
  logic signed [PROD_W-1:0]  acc_shr;
  logic signed [RAW_W-1:0]   raw_sat;
  logic [RAW_W:0]            diff_mag;
  logic signed [RES_W-1:0]   res, res_clamp;
  logic signed [RES_W-1:0]   lim_pos, lim_neg;

  assign accept     = in_tvalid && in_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_err     = signed'(in_tdata[ERROR_BITS-1:0]);
  assign in_now     = in_tdata[ERROR_BITS +: TIME_W];
  assign in_elapsed = in_now - last_time_r;
  assign in_err_mag = in_err[ERROR_BITS-1] ? ERROR_BITS'(-in_err) : ERROR_BITS'(in_err);
  assign integrate  = in_err_mag > {1'b0, thr_r};

  assign mul_last = (cnt_r == CNT_W'(MUL_LAST));
  assign div_last = (cnt_r == CNT_W'(DIV_LAST));

  // one shift-add step; the top bit of a signed multiplier weighs negative
  assign mul_term = (mul_last && msgn_r) ? -mcand_r : mcand_r;
  assign mul_acc  = mplier_r[0] ? acc_r + mul_term : acc_r;

  // one restoring divide step
  assign rtry    = {rem_r, dvd_r[DIV_W-1]};
  assign rsub    = rtry - {1'b0, dvsr_r};
  assign dge     = (rtry >= {1'b0, dvsr_r});
  assign div_rem = dge ? rsub[REM_W-1:0] : rtry[REM_W-1:0];
  assign div_dvd = {dvd_r[DIV_W-2:0], dge};

  // saturating integral update
  assign acc_sum = {accum_r[ACC_W-1], accum_r} + {acc_r[ACC_W-1], acc_r[ACC_W-1:0]};
  always_comb begin
    if (acc_sum[ACC_W] == acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W-1:0];
    end else if (acc_sum[ACC_W]) begin
      acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  // divider operands
  assign accum_mag = accum_r[ACC_W-1] ? ACC_W'(-accum_r) : ACC_W'(accum_r);
  assign derr_mag  = derr_r[ERROR_BITS] ? (ERROR_BITS+1)'(-derr_r)
                                        : (ERROR_BITS+1)'(derr_r);
  assign num_mag   = NUM_W'(derr_mag) * NUM_W'(MS_PER_S);

  // Q56.8 sum back to integer, floor, then 32-bit saturation
  assign acc_shr = acc_r >>> 8;
  always_comb begin
    if (&acc_shr[PROD_W-1:RAW_W-1] || ~|acc_shr[PROD_W-1:RAW_W-1]) begin
      raw_sat = acc_shr[RAW_W-1:0];
    end else if (acc_shr[PROD_W-1]) begin
      raw_sat = {1'b1, {(RAW_W-1){1'b0}}};
    end else begin
      raw_sat = {1'b0, {(RAW_W-1){1'b1}}};
    end
  end

  // slew limit and output clamp
  assign diff_mag = diff_r[RAW_W] ? (RAW_W+1)'(-diff_r) : (RAW_W+1)'(diff_r);
  assign lim_pos  = signed'(RES_W'(OUTPUT_LIMIT));
  assign lim_neg  = -lim_pos;
  always_comb begin
    if (elapsed_r == '0 || raw_r == '0) begin
      res = '0;
    end else if (STEP_W'(diff_mag) > step_r) begin
      res = diff_r[RAW_W]
          ? RES_W'(prev_raw_r) - signed'(RES_W'(step_r))
          : RES_W'(prev_raw_r) + signed'(RES_W'(step_r));
    end else begin
      res = RES_W'(raw_r);
    end
    if (res > lim_pos) begin
      res_clamp = lim_pos;
    end else if (res < lim_neg) begin
      res_clamp = lim_neg;
    end else begin
      res_clamp = res;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pass_nxt      = pass_r;
    last_time_nxt = last_time_r;
    prev_err_nxt  = prev_err_r;
    accum_nxt     = accum_r;
    prev_raw_nxt  = prev_raw_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    err_nxt       = err_r;
    derr_nxt      = derr_r;
    elapsed_nxt   = elapsed_r;
    q_nxt         = q_r;
    rate_nxt      = rate_r;
    raw_nxt       = raw_r;
    diff_nxt      = diff_r;
    step_nxt      = step_r;
    dneg_nxt      = dneg_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    msgn_nxt      = msgn_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dvsr_nxt      = dvsr_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser) begin
            accum_nxt    = '0;
            prev_err_nxt = '0;
            prev_raw_nxt = '0;
          end else begin
            last_time_nxt = in_now;
            prev_err_nxt  = in_err;
            err_nxt       = in_err;
            derr_nxt      = {in_err[ERROR_BITS-1], in_err}
                          - {prev_err_r[ERROR_BITS-1], prev_err_r};
            elapsed_nxt   = in_elapsed;
            if (integrate) begin
              acc_nxt    = '0;
              mcand_nxt  = signed'({{(PROD_W-TIME_W){1'b0}}, in_elapsed});
              mplier_nxt = in_err;
              msgn_nxt   = 1'b1;
              cnt_nxt    = '0;
              state_nxt  = ST_IMUL;
            end else begin
              state_nxt = ST_ALOAD;
            end
          end
        end
      end
      ST_IMUL: begin
        acc_nxt    = mul_acc;
        mcand_nxt  = mcand_r <<< 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (mul_last) begin
          state_nxt = ST_IACC;
        end
      end
      ST_IACC: begin
        accum_nxt = acc_sat;
        state_nxt = ST_ALOAD;
      end
      ST_ALOAD: begin
        dvd_nxt   = accum_mag;
        dvsr_nxt  = REM_W'(MS_PER_S);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        dneg_nxt  = accum_r[ACC_W-1];
        state_nxt = ST_ADIV;
      end
      ST_ADIV: begin
        dvd_nxt = div_dvd;
        rem_nxt = div_rem;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (div_last) begin
          q_nxt = dneg_r ? -signed'(div_dvd[QUOT_W-1:0]) : signed'(div_dvd[QUOT_W-1:0]);
          cnt_nxt = '0;
          if (elapsed_r != '0) begin
            dvd_nxt   = DIV_W'(num_mag);
            dvsr_nxt  = elapsed_r;
            rem_nxt   = '0;
            dneg_nxt  = derr_r[ERROR_BITS];
            state_nxt = ST_RDIV;
          end else begin
            rate_nxt   = '0;
            acc_nxt    = '0;
            mcand_nxt  = {{(PROD_W-ERROR_BITS){err_r[ERROR_BITS-1]}}, err_r};
            mplier_nxt = kp_r;
            msgn_nxt   = 1'b1;
            pass_nxt   = '0;
            state_nxt  = ST_PMUL;
          end
        end
      end
      ST_RDIV: begin
        dvd_nxt = div_dvd;
        rem_nxt = div_rem;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (div_last) begin
          rate_nxt   = dneg_r ? -signed'(div_dvd[RATE_W-1:0])
                              : signed'(div_dvd[RATE_W-1:0]);
          cnt_nxt    = '0;
          acc_nxt    = '0;
          mcand_nxt  = {{(PROD_W-ERROR_BITS){err_r[ERROR_BITS-1]}}, err_r};
          mplier_nxt = kp_r;
          msgn_nxt   = 1'b1;
          pass_nxt   = '0;
          state_nxt  = ST_PMUL;
        end
      end
      ST_PMUL: begin
        // three products summed in one accumulator: P, then I, then D
        acc_nxt    = mul_acc;
        mcand_nxt  = mcand_r <<< 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (mul_last) begin
          cnt_nxt = '0;
          if (pass_r == 2'd2) begin
            state_nxt = ST_RAW;
          end else if (pass_r == 2'd0) begin
            pass_nxt   = 2'd1;
            mcand_nxt  = {{(PROD_W-QUOT_W){q_r[QUOT_W-1]}}, q_r};
            mplier_nxt = ki_r;
          end else begin
            pass_nxt   = 2'd2;
            mcand_nxt  = {{(PROD_W-RATE_W){rate_r[RATE_W-1]}}, rate_r};
            mplier_nxt = kd_r;
          end
        end
      end
      ST_RAW: begin
        raw_nxt    = raw_sat;
        acc_nxt    = '0;
        mcand_nxt  = signed'({{(PROD_W-TIME_W){1'b0}}, elapsed_r});
        mplier_nxt = slew_r;
        msgn_nxt   = 1'b0;
        cnt_nxt    = '0;
        state_nxt  = ST_BMUL;
      end
      ST_BMUL: begin
        // slew budget in output units times ms
        acc_nxt    = mul_acc;
        mcand_nxt  = mcand_r <<< 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        diff_nxt   = {raw_r[RAW_W-1], raw_r} - {prev_raw_r[RAW_W-1], prev_raw_r};
        if (mul_last) begin
          dvd_nxt   = mul_acc[DIV_W-1:0];
          dvsr_nxt  = REM_W'(MS_PER_S);
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_BDIV;
        end
      end
      ST_BDIV: begin
        dvd_nxt = div_dvd;
        rem_nxt = div_rem;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (div_last) begin
          step_nxt  = div_dvd[STEP_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_clamp[DRIVE_W-1:0];
          prev_raw_nxt  = raw_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      ki_r   <= '0;
      kd_r   <= '0;
      thr_r  <= '0;
      slew_r <= '1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_KP:   kp_r   <= cfg_wdata;
        CFG_KI:   ki_r   <= cfg_wdata;
        CFG_KD:   kd_r   <= cfg_wdata;
        CFG_THR:  thr_r  <= cfg_wdata[THR_W-1:0];
        CFG_SLEW: slew_r <= cfg_wdata[SLEW_W-1:0];
        default: ;
      endcase
    end
  end

  // control state and loop memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pass_r      <= '0;
      last_time_r <= '0;
      prev_err_r  <= '0;
      accum_r     <= '0;
      prev_raw_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pass_r      <= pass_nxt;
      last_time_r <= last_time_nxt;
      prev_err_r  <= prev_err_nxt;
      accum_r     <= accum_nxt;
      prev_raw_r  <= prev_raw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    err_r      <= err_nxt;
    derr_r     <= derr_nxt;
    elapsed_r  <= elapsed_nxt;
    q_r        <= q_nxt;
    rate_r     <= rate_nxt;
    raw_r      <= raw_nxt;
    diff_r     <= diff_nxt;
    step_r     <= step_nxt;
    dneg_r     <= dneg_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    msgn_r     <= msgn_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    dvsr_r     <= dvsr_nxt;
  end

endmodule
`default_nettype wire

// ===== src/pslc_checker.sv =====
// Port-level checker for the slew-limited PID controller, bound to the top level
`default_nettype none
`include "pid_slew_limited_controller_defines.svh"
module pslc_checker import pslc_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tvalid,
  input wire logic               in_tready,
  input wire logic               in_tuser,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [DRIVE_W-1:0] out_tdata
);

  // stalled result holds
  `PSLC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // drive value never reaches the most negative code
  `PSLC_ASSERT(a_out_range, out_tvalid |-> out_tdata != {1'b1, {(DRIVE_W-1){1'b0}}}, "drive value out of range")

  // a reset request completes at once
  `PSLC_ASSERT(a_rst_cmd, in_tvalid && in_tready && in_tuser |=> in_tready, "busy after reset request")

  // an execute request keeps the block busy
  `PSLC_ASSERT(a_exec_busy, in_tvalid && in_tready && !in_tuser |=> !in_tready, "ready right after execute request")

  // no result straight out of reset
  `PSLC_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind pid_slew_limited_controller pslc_checker u_pslc_checker (.*);
`default_nettype wire
